@@ src/brl16_pkg.sv @@
// Shared types, constants and the mask helper for the bounded random generator.
// Depends on nothing; every other file of the block imports it.

package brl16_pkg;

   localparam int unsigned DataWidth = 16;

   localparam logic [DataWidth-1:0] SeedValue = 16'hACE1;
   localparam logic [DataWidth-1:0] TapMask   = 16'hB400;
   localparam logic [DataWidth-1:0] FullMask  = 16'hFFFF;
   localparam logic [DataWidth-1:0] LastStep  = 16'hFFFE;

   typedef logic [DataWidth-1:0] data_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_STEP = 3'b010,
      ST_PUT  = 3'b100
   } brl16_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } brl16_cmd_type;

   typedef struct packed {
      logic special;
      logic hit;
      logic out_free;
   } brl16_sts_type;

   // Smallest all-ones value above spread, capped at 15 ones; a spread with
   // its top bit set takes the full 16-bit mask. The smeared spread is already
   // above spread unless spread is itself a run of ones, which needs one more.
   function automatic data_type cover_mask(input data_type spread);
      data_type smear;
      smear = spread;
      smear = smear | (smear >> 1);
      smear = smear | (smear >> 2);
      smear = smear | (smear >> 4);
      smear = smear | (smear >> 8);
      if (spread[DataWidth-1]) begin
         return FullMask;
      end
      if (smear != spread) begin
         return smear;
      end
      return {1'b0, smear[DataWidth-3:0], 1'b1};
   endfunction

endpackage

@@ src/brl16_if.sv @@
// Valid/ready channel interfaces for the request and response words.
// Depends on brl16_pkg for the data type.

interface brl16_req_if import brl16_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type lower_bound;
   data_type upper_bound;

   modport source (output valid, output lower_bound, output upper_bound, input ready);
   modport sink   (input valid, input lower_bound, input upper_bound, output ready);
endinterface

interface brl16_rsp_if import brl16_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type random_value;

   modport source (output valid, output random_value, input ready);
   modport sink   (input valid, input random_value, output ready);
endinterface

@@ src/brl16_datapath.sv @@
// Datapath: LFSR, bound registers, rejection compare and the output register.
// Depends on brl16_pkg; driven by brl16_ctrl through command and status structs.

module brl16_datapath import brl16_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  brl16_cmd_type cmd,
   output brl16_sts_type sts,
   input  data_type      lower_bound,
   input  data_type      upper_bound,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output data_type      random_value
);

   data_type shift_ff,  shift_in;
   data_type lower_ff,  lower_in;
   data_type spread_ff, spread_in;
   data_type mask_ff,   mask_in;
   data_type pick_ff,   pick_in;
   data_type count_ff,  count_in;
   logic     empty_ff,  empty_in;
   data_type rsp_data_ff, rsp_data_in;
   logic     rsp_valid_ff, rsp_valid_in;

   data_type lfsr_next;
   data_type masked;
   data_type diff;

   always_comb begin
      lfsr_next = {1'b0, shift_ff[DataWidth-1:1]} ^ (shift_ff[0] ? TapMask : '0);
      masked    = lfsr_next & mask_ff;
      diff      = upper_bound - lower_bound;

      sts.special  = (lower_bound >= upper_bound);
      sts.hit      = (masked <= spread_ff) || (count_ff == LastStep);
      sts.out_free = !rsp_valid_ff || rsp_ready;

      shift_in     = shift_ff;
      lower_in     = lower_ff;
      spread_in    = spread_ff;
      mask_in      = mask_ff;
      pick_in      = pick_ff;
      count_in     = count_ff;
      empty_in     = empty_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.load) begin
         lower_in  = lower_bound;
         spread_in = diff;
         mask_in   = cover_mask(diff);
         pick_in   = '0;
         count_in  = '0;
         empty_in  = (lower_bound > upper_bound);
      end
      if (cmd.step) begin
         shift_in = lfsr_next;
         pick_in  = masked;
         count_in = count_ff + 1'b1;
      end
      if (cmd.emit) begin
         rsp_data_in  = empty_ff ? '0 : pick_ff + lower_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= SeedValue;
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lower_ff    <= lower_in;
      spread_ff   <= spread_in;
      mask_ff     <= mask_in;
      pick_ff     <= pick_in;
      count_ff    <= count_in;
      empty_ff    <= empty_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign random_value = rsp_data_ff;

endmodule

@@ src/brl16_ctrl.sv @@
// Controller state machine: request intake, rejection loop, handoff to output.
// Depends on brl16_pkg for the state, command and status types.

module brl16_ctrl import brl16_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  brl16_sts_type sts,
   output brl16_cmd_type cmd
);

   brl16_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.special ? ST_PUT : ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (sts.hit) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/bounded_random_lfsr16.sv @@
// Top level of the bounded pseudo-random generator.
// Depends on brl16_pkg, brl16_if, brl16_ctrl and brl16_datapath.

// Each request word carries a lower and an upper bound and returns one response
// word holding a pseudo-random value in that range. The source is a 16-bit
// right-shifting Galois LFSR with taps 0xB400, seeded with 0xACE1 at reset. If
// lower exceeds upper the response is 0; if they are equal it is the lower
// bound; in both cases the LFSR does not move. Otherwise the LFSR steps once
// per cycle and its value, masked to the smallest all-ones pattern above the
// spread, is rejected until it falls within the spread, then lower is added.
// A request passes through intake in ST_IDLE, the LFSR steps of the rejection loop
// in ST_STEP and the load of the output register in ST_PUT, which waits while the
// output register still holds an untaken word. Empty or single-value ranges skip
// ST_STEP. The output register holds a finished word until it is taken, and the
// block accepts the next request meanwhile.

module bounded_random_lfsr16 import brl16_pkg::*; (
   input logic         clock,
   input logic         reset,
   brl16_req_if.sink   req,
   brl16_rsp_if.source rsp
);

   brl16_cmd_type cmd;
   brl16_sts_type sts;

   // Sequencing and the state register live in the controller; all other storage and arithmetic in the datapath.
   brl16_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   brl16_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .lower_bound  (req.lower_bound),
      .upper_bound  (req.upper_bound),
      .rsp_valid    (rsp.valid),
      .rsp_ready    (rsp.ready),
      .random_value (rsp.random_value)
   );

endmodule
